// ===== rtl/recursive_sine_oscillator_mixer_defines.svh =====
// Assertion macros used by the oscillator mixer controller.
`ifndef RECURSIVE_SINE_OSCILLATOR_MIXER_DEFINES_SVH
`define RECURSIVE_SINE_OSCILLATOR_MIXER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RSOM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define RSOM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsom_pkg.sv =====
// Shared types and constants of the recursive sine oscillator mixer.
`default_nettype none
package rsom_pkg;

    localparam int STATE_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 30;
    localparam int CFG_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int MUL_A_WIDTH     = 32;
    localparam int MUL_B_WIDTH     = 31;
    localparam int MUL_P_WIDTH     = MUL_A_WIDTH + MUL_B_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEFFICIENT   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_VALUE   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESTART_COUNT = 2'd2;

    localparam logic signed [CFG_WIDTH-1:0] COEFFICIENT_RESET   = 32'sd2146747759;
    localparam logic signed [CFG_WIDTH-1:0] START_VALUE_RESET   = 32'sd28107286;
    localparam logic        [CFG_WIDTH-1:0] RESTART_COUNT_RESET = 32'd9600000;

    localparam logic signed [MUL_A_WIDTH-1:0] TONE_SCALE = 32'sd28000;

    typedef struct packed {
        logic in_load;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic tone_lo;
        logic tone_hi;
        logic out_load;
    } t_rsom_cmd;

endpackage
`default_nettype wire

// ===== rtl/rsom_ctrl.sv =====
// Sequencing controller of the oscillator mixer: steps the datapath per transaction.
`default_nettype none
`include "recursive_sine_oscillator_mixer_defines.svh"
module rsom_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  wire               i_m_tready,
    output rsom_pkg::t_rsom_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_TONE_LO,
        S_TONE_HI,
        S_OUT
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    rsom_pkg::t_rsom_cmd w_cmd;

    always_comb begin
        w_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_m_tready;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    w_cmd.in_load = 1'b1;
                    n_state       = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                w_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                w_cmd.mul_hi = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                w_cmd.sum = 1'b1;
                n_state   = S_TONE_LO;
            end
            S_TONE_LO: begin
                w_cmd.tone_lo = 1'b1;
                n_state       = S_TONE_HI;
            end
            S_TONE_HI: begin
                w_cmd.tone_hi = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    w_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = i_rst_n && (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = w_cmd;

    `RSOM_ASSERT_NEXT(a_accept_starts, w_cmd.in_load, r_state == S_MUL_LO, "multiply not started")
    `RSOM_ASSERT_SAME(a_cmd_single, 1'b1, $onehot0(w_cmd), "several datapath commands at once")
    `RSOM_ASSERT_SAME(a_out_slot_free, w_cmd.out_load, !r_out_valid || i_m_tready, "result lost")
    `RSOM_ASSERT_NEXT(a_out_valid_after_load, w_cmd.out_load, r_out_valid, "result not shown")

endmodule
`default_nettype wire

// ===== rtl/rsom_datapath.sv =====
// Datapath of the oscillator mixer: registers, shared multiplier, tone and mix logic.
`default_nettype none
module rsom_datapath #(
    parameter int STATE_WIDTH = rsom_pkg::STATE_WIDTH_DEF
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_cfg_we,
    input  wire  [rsom_pkg::CFG_INDEX_WIDTH-1:0]      i_cfg_index,
    input  wire  [rsom_pkg::CFG_WIDTH-1:0]            i_cfg_data,
    input  wire  signed [rsom_pkg::SAMPLE_WIDTH-1:0]  i_sample_left,
    input  wire  signed [rsom_pkg::SAMPLE_WIDTH-1:0]  i_sample_right,
    input  wire                                       i_block_end,
    input  rsom_pkg::t_rsom_cmd                       i_cmd,
    output logic signed [rsom_pkg::SAMPLE_WIDTH-1:0]  o_tone,
    output logic signed [rsom_pkg::SAMPLE_WIDTH-1:0]  o_mixed_left,
    output logic signed [rsom_pkg::SAMPLE_WIDTH-1:0]  o_mixed_right,
    output logic                                      o_block_end_out
);

    localparam int FB  = rsom_pkg::FRAC_BITS;
    localparam int SW  = rsom_pkg::SAMPLE_WIDTH;
    localparam int PW  = rsom_pkg::MUL_P_WIDTH;
    localparam int BW  = rsom_pkg::MUL_B_WIDTH;
    localparam int XW  = (STATE_WIDTH > FB + 1) ? STATE_WIDTH : FB + 1;
    localparam int HW  = XW - FB;
    localparam int EXW = 64;

    localparam logic signed [PW-1:0] TONE_MAX = PW'(32767);
    localparam logic signed [PW-1:0] TONE_MIN = -PW'(32768);

    logic signed [rsom_pkg::CFG_WIDTH-1:0] r_coef;
    logic signed [rsom_pkg::CFG_WIDTH-1:0] r_start;
    logic        [rsom_pkg::CFG_WIDTH-1:0] r_restart;
    logic signed [STATE_WIDTH-1:0]         r_prev;
    logic signed [STATE_WIDTH-1:0]         r_pprev;
    logic        [rsom_pkg::CFG_WIDTH-1:0] r_steps;
    logic signed [SW-1:0]                  r_left;
    logic signed [SW-1:0]                  r_right;
    logic                                  r_last;
    logic signed [PW-1:0]                  r_prod;
    logic        [STATE_WIDTH-1:0]         r_acc;
    logic        [SW-1:0]                  r_tadd;
    logic signed [SW-1:0]                  r_tone;
    logic signed [SW-1:0]                  r_mixl;
    logic signed [SW-1:0]                  r_mixr;
    logic                                  r_last_out;

    logic signed [EXW-1:0]                 w_start_ext;
    logic signed [XW-1:0]                  w_prev_x;
    logic signed [HW-1:0]                  w_hi;
    logic signed [rsom_pkg::MUL_A_WIDTH-1:0] w_a;
    logic signed [BW-1:0]                  w_b;
    logic signed [PW-1:0]                  w_mul;
    logic        [STATE_WIDTH-1:0]         w_y;
    logic                                  w_round;
    logic signed [PW-1:0]                  w_q;
    logic signed [SW-1:0]                  w_tone;
    logic signed [SW-1:0]                  w_part;

    assign w_start_ext = EXW'(r_start);
    assign w_prev_x    = XW'(r_prev);
    assign w_hi        = w_prev_x[XW-1:FB];

    assign w_a   = (i_cmd.tone_lo || i_cmd.tone_hi) ? rsom_pkg::TONE_SCALE : r_coef;
    assign w_b   = (i_cmd.mul_lo || i_cmd.tone_lo) ? $signed({1'b0, w_prev_x[FB-1:0]})
                                                   : BW'(w_hi);
    assign w_mul = w_a * w_b;

    assign w_y     = r_prod[STATE_WIDTH-1:0] + r_acc - r_pprev;
    assign w_round = r_prev[STATE_WIDTH-1] && (r_prod[FB-1:0] != '0);
    assign w_q     = r_prod + $signed({{(PW-SW){1'b0}}, r_tadd});

    always_comb begin
        if (w_q > TONE_MAX) begin
            w_tone = SW'(TONE_MAX);
        end else if (w_q < TONE_MIN) begin
            w_tone = SW'(TONE_MIN);
        end else begin
            w_tone = w_q[SW-1:0];
        end
    end

    assign w_part = w_tone >>> 4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef    <= rsom_pkg::COEFFICIENT_RESET;
            r_start   <= rsom_pkg::START_VALUE_RESET;
            r_restart <= rsom_pkg::RESTART_COUNT_RESET;
            r_prev    <= '0;
            r_pprev   <= '0;
            r_steps   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rsom_pkg::REG_COEFFICIENT:   r_coef    <= i_cfg_data;
                    rsom_pkg::REG_START_VALUE:   r_start   <= i_cfg_data;
                    rsom_pkg::REG_RESTART_COUNT: r_restart <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.in_load) begin
                if (r_steps != '0) begin
                    r_steps <= r_steps - 1'b1;
                end else begin
                    r_prev  <= w_start_ext[STATE_WIDTH-1:0];
                    r_pprev <= '0;
                    r_steps <= r_restart;
                end
            end
            if (i_cmd.sum) begin
                r_pprev <= r_prev;
                r_prev  <= w_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_left  <= i_sample_left;
            r_right <= i_sample_right;
            r_last  <= i_block_end;
        end
        if (i_cmd.mul_lo || i_cmd.mul_hi || i_cmd.tone_lo || i_cmd.tone_hi) begin
            r_prod <= w_mul;
        end
        if (i_cmd.mul_hi) begin
            r_acc <= STATE_WIDTH'(r_prod >>> FB);
        end
        if (i_cmd.tone_hi) begin
            r_tadd <= SW'(r_prod >>> FB) + SW'(w_round);
        end
        if (i_cmd.out_load) begin
            r_tone     <= w_tone;
            r_mixl     <= r_left + w_part;
            r_mixr     <= r_right + w_part;
            r_last_out <= r_last;
        end
    end

    assign o_tone          = r_tone;
    assign o_mixed_left    = r_mixl;
    assign o_mixed_right   = r_mixr;
    assign o_block_end_out = r_last_out;

endmodule
`default_nettype wire

// ===== rtl/recursive_sine_oscillator_mixer.sv =====
// Top level of the recursive sine oscillator mixer.
`default_nettype none
// Two-pole recursive sine oscillator whose tone is mixed into a stereo stream. Each
// input transaction advances the oscillator by one step and returns one result: the
// saturated tone and both input samples with the tone, shifted right by four, added
// with wraparound. A single 32x31 multiplier is used four times per step, twice for
// the feedback product and twice for the tone scaling. A finished result waits in
// the output register while the next transaction is taken. Registers (0 coefficient,
// 1 start value, 2 restart count) must be written through i_cfg_* only while the
// block is idle; the block itself does not enforce this.
module recursive_sine_oscillator_mixer #(
    parameter int STATE_WIDTH = rsom_pkg::STATE_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // sample_left [15:0], sample_right [31:16]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // tone [15:0], mixed_left [31:16], mixed_right [47:32]
    output logic        m_axis_tlast
);

    rsom_pkg::t_rsom_cmd w_cmd;
    logic signed [15:0]  w_tone;
    logic signed [15:0]  w_mixl;
    logic signed [15:0]  w_mixr;

    rsom_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd)
    );

    rsom_datapath #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample_left   (s_axis_tdata[15:0]),
        .i_sample_right  (s_axis_tdata[31:16]),
        .i_block_end     (s_axis_tlast),
        .i_cmd           (w_cmd),
        .o_tone          (w_tone),
        .o_mixed_left    (w_mixl),
        .o_mixed_right   (w_mixr),
        .o_block_end_out (m_axis_tlast)
    );

    assign m_axis_tdata = {w_mixr, w_mixl, w_tone};

endmodule
`default_nettype wire
